// ===== design/assert_macros.svh =====
// Assertion helpers included by the estimator design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that an implication holds in the cycle after its antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rls_pkg.sv =====
package rls_pkg;
   localparam int ORDER_DEFAULT = 2;
   localparam int MAX_ORDER     = 4;
   localparam logic [16:0] LAMBDA_RESET = 17'd64880;
   localparam logic [30:0] PDIAG_RESET  = 31'd6553600;

   localparam logic CSR_LAMBDA = 1'b0;
   localparam logic CSR_PDIAG  = 1'b1;

   localparam logic KIND_UPDATE  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_S,
      ST_V,
      ST_Q,
      ST_KDIV,
      ST_T,
      ST_PDIV,
      ST_W,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction
endpackage

// ===== design/rls_adaptive_estimator.sv =====
// Channel    | Direction | Handshake             | Payload
// req        | in        | req_valid / req_stall | kind, regressor_0..3, target, prediction
// rsp        | out       | rsp_valid / rsp_stall | weight_0..3, prior_error
// csr        | in        | csr_write_enable      | csr_index, csr_write_data (31 bits)
//
// One 32x32 multiplier and one 48-bit restoring divider are shared by the update steps.
// An update runs, after acceptance, 2*N*N products for P*x and x'*P, N for q, N gain
// divisions (a zero denominator saturates the gain without dividing), N*N products each
// followed by a division by lambda, N weight products and an output step. A restart goes
// straight to the output step.
// Reset is synchronous and clears W and P. A result beat holds until taken; hold requests.
module rls_adaptive_estimator
   import rls_pkg::*;
#(
   parameter int ORDER = ORDER_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic signed [31:0] req_regressor_0,
   input  logic signed [31:0] req_regressor_1,
   input  logic signed [31:0] req_regressor_2,
   input  logic signed [31:0] req_regressor_3,
   input  logic signed [31:0] req_target_value,
   input  logic signed [31:0] req_predicted_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_weight_0,
   output logic signed [31:0] rsp_weight_1,
   output logic signed [31:0] rsp_weight_2,
   output logic signed [31:0] rsp_weight_3,
   output logic signed [31:0] rsp_prior_error,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [30:0]        csr_write_data
);
   localparam int NN = ORDER * ORDER;
   localparam int IW = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int PW = (NN > 1) ? $clog2(NN) : 1;
   localparam int DIVW = 48;

   `include "assert_macros.svh"

   state_type state_ff, state_in;
   logic [16:0] lambda_ff;
   logic [30:0] pdiag_ff;
   logic signed [31:0] p_ff [NN];
   logic signed [31:0] w_ff [ORDER];
   logic signed [31:0] x_ff [ORDER];
   logic signed [31:0] s_ff [ORDER];
   logic signed [31:0] v_ff [ORDER];
   logic signed [31:0] k_ff [ORDER];
   logic signed [31:0] e_ff;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] q_ff;
   logic [IW-1:0] i_ff, j_ff;
   logic first_ff;
   logic restart_ff;
   logic rsp_valid_ff;

   // divider: magnitude restoring, one quotient bit a cycle
   logic [DIVW-1:0] dq_ff, dr_ff, dd_ff;
   logic [5:0] dcnt_ff;
   logic dneg_ff, dbusy_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod, prodfl;
   logic [IW-1:0] i_last, j_last;

   assign i_last = IW'(ORDER - 1);
   assign j_last = IW'(ORDER - 1);

   function automatic logic [PW-1:0] pidx(input logic [IW-1:0] r, input logic [IW-1:0] c);
      return PW'(int'(r) * ORDER + int'(c));
   endfunction

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_S: begin mul_a = p_ff[pidx(i_ff, j_ff)]; mul_b = x_ff[j_ff]; end
         ST_V: begin mul_a = x_ff[i_ff]; mul_b = p_ff[pidx(i_ff, j_ff)]; end
         ST_Q: begin mul_a = v_ff[j_ff]; mul_b = x_ff[j_ff]; end
         ST_T: begin mul_a = k_ff[i_ff]; mul_b = v_ff[j_ff]; end
         ST_W: begin mul_a = k_ff[i_ff]; mul_b = e_ff; end
         default: ;
      endcase
   end
   assign prod   = mul_a * mul_b;
   assign prodfl = prod >>> 16;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   logic signed [63:0] lam_s, dnum, dden, tval;
   logic [63:0] dabs;
   logic [DIVW-1:0] nmag, dmag, rtry;
   assign lam_s = (lambda_ff == '0) ? 64'sd1 : 64'($unsigned(lambda_ff));
   assign tval  = 64'(sat32(64'(p_ff[pidx(i_ff, j_ff)]) - prodfl));
   assign rtry  = {dr_ff[DIVW-2:0], dq_ff[DIVW-1]};

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid && !req_stall)
                     state_in = (req_kind == KIND_RESTART) ? ST_OUT : ST_S;
         ST_S: begin
            acc_in = acc_ff + prodfl;
            if (j_ff == j_last) begin
               acc_in = '0;
               if (i_ff == i_last) state_in = ST_V;
            end
         end
         ST_V: begin
            acc_in = acc_ff + prodfl;
            if (i_ff == i_last) begin
               acc_in = '0;
               if (j_ff == j_last) state_in = ST_Q;
            end
         end
         ST_Q:    if (j_ff == j_last) state_in = ST_KDIV;
         ST_KDIV: if (i_ff == i_last &&
                      ((dbusy_ff && dcnt_ff == 6'd1) || (!dbusy_ff && dden == '0)))
                     state_in = ST_T;
         ST_T:    state_in = ST_PDIV;
         ST_PDIV: if (dbusy_ff && dcnt_ff == 6'd1)
                     state_in = (i_ff == i_last && j_ff == j_last) ? ST_W : ST_T;
         ST_W:    if (i_ff == i_last) state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
      end
   end

   assign dnum = (state_ff == ST_KDIV) ? 64'(s_ff[i_ff]) : tval;
   assign dden = (state_ff == ST_KDIV) ? q_ff + lam_s : lam_s;
   assign nmag = DIVW'(dnum[63] ? -dnum : dnum) << 16;
   assign dabs = dden[63] ? -dden : dden;
   // a divisor beyond the divider width gives a zero quotient; clamp it to all ones
   assign dmag = (dabs[63:DIVW] != '0) ? '1 : dabs[DIVW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff    <= LAMBDA_RESET;
         pdiag_ff     <= PDIAG_RESET;
         rsp_valid_ff <= 1'b0;
         dbusy_ff     <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         for (int n = 0; n < NN; n++) p_ff[n] <= '0;
         for (int n = 0; n < ORDER; n++) w_ff[n] <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_LAMBDA: lambda_ff <= csr_write_data[16:0];
               CSR_PDIAG:  pdiag_ff  <= csr_write_data;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_valid && !req_stall) begin
               restart_ff <= req_kind;
               x_ff[0] <= req_regressor_0;
               if (ORDER > 1) x_ff[IW'(1 % ORDER)] <= req_regressor_1;
               if (ORDER > 2) x_ff[IW'(2 % ORDER)] <= req_regressor_2;
               if (ORDER > 3) x_ff[IW'(3 % ORDER)] <= req_regressor_3;
               e_ff <= (req_kind == KIND_RESTART) ? 32'sd0 :
                       sat32(64'(req_target_value) - 64'(req_predicted_value));
               i_ff <= '0; j_ff <= '0; q_ff <= '0;
            end
            ST_S: begin
               if (j_ff == j_last) begin
                  s_ff[i_ff] <= sat32(acc_ff + prodfl);
                  j_ff <= '0;
                  i_ff <= (i_ff == i_last) ? '0 : i_ff + 1'b1;
               end else j_ff <= j_ff + 1'b1;
            end
            ST_V: begin
               if (i_ff == i_last) begin
                  v_ff[j_ff] <= sat32(acc_ff + prodfl);
                  i_ff <= '0;
                  j_ff <= (j_ff == j_last) ? '0 : j_ff + 1'b1;
               end else i_ff <= i_ff + 1'b1;
            end
            ST_Q: begin
               q_ff <= q_ff + prodfl;
               j_ff <= (j_ff == j_last) ? '0 : j_ff + 1'b1;
            end
            ST_KDIV, ST_PDIV: begin
               if (!dbusy_ff) begin
                  if (state_ff == ST_KDIV && dden == 0) begin
                     // zero denominator: saturate by sign of numerator
                     k_ff[i_ff] <= (s_ff[i_ff] > 0) ? 32'sh7FFFFFFF :
                                   (s_ff[i_ff] < 0) ? 32'sh80000000 : 32'sd0;
                     i_ff <= (i_ff == i_last) ? '0 : i_ff + 1'b1;
                  end else begin
                     dq_ff <= nmag; dr_ff <= '0; dd_ff <= dmag;
                     dneg_ff <= dnum[63] ^ dden[63];
                     dcnt_ff <= 6'(DIVW); dbusy_ff <= 1'b1;
                  end
               end else begin
                  if (rtry >= dd_ff) begin
                     dr_ff <= rtry - dd_ff; dq_ff <= {dq_ff[DIVW-2:0], 1'b1};
                  end else begin
                     dr_ff <= rtry; dq_ff <= {dq_ff[DIVW-2:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff - 1'b1;
                  if (dcnt_ff == 6'd1) dbusy_ff <= 1'b0;
               end
               if (dbusy_ff && dcnt_ff == 6'd1) begin
                  if (state_ff == ST_KDIV) begin
                     k_ff[i_ff] <= sat32(dneg_ff ?
                        -$signed({16'd0, dq_ff[DIVW-2:0], (rtry >= dd_ff)}) :
                         $signed({16'd0, dq_ff[DIVW-2:0], (rtry >= dd_ff)}));
                     i_ff <= (i_ff == i_last) ? '0 : i_ff + 1'b1;
                  end else begin
                     p_ff[pidx(i_ff, j_ff)] <= sat32(dneg_ff ?
                        -$signed({16'd0, dq_ff[DIVW-2:0], (rtry >= dd_ff)}) :
                         $signed({16'd0, dq_ff[DIVW-2:0], (rtry >= dd_ff)}));
                     if (j_ff == j_last) begin
                        j_ff <= '0;
                        i_ff <= (i_ff == i_last) ? '0 : i_ff + 1'b1;
                     end else j_ff <= j_ff + 1'b1;
                  end
               end
            end
            ST_T: p_ff[pidx(i_ff, j_ff)] <= tval[31:0];
            ST_W: begin
               w_ff[i_ff] <= sat32(64'(w_ff[i_ff]) + prodfl);
               i_ff <= (i_ff == i_last) ? '0 : i_ff + 1'b1;
            end
            ST_OUT: begin
               if (restart_ff) begin
                  // load identity scaled by the restart diagonal
                  for (int r = 0; r < ORDER; r++) begin
                     w_ff[r] <= '0;
                     for (int c = 0; c < ORDER; c++)
                        p_ff[r * ORDER + c] <= (r == c) ? $signed({1'b0, pdiag_ff}) : '0;
                  end
               end
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   logic signed [31:0] wout [MAX_ORDER];
   always_comb begin
      for (int n = 0; n < MAX_ORDER; n++) wout[n] = '0;
      for (int n = 0; n < ORDER; n++) wout[n] = w_ff[n];
   end
   assign rsp_weight_0    = wout[0];
   assign rsp_weight_1    = wout[1];
   assign rsp_weight_2    = wout[2];
   assign rsp_weight_3    = wout[3];
   assign rsp_prior_error = e_ff;

   `ASSERT_IMPLY(a_no_accept_busy, clock, reset, (state_ff != ST_IDLE), req_stall,
                 "request taken while busy")
   `ASSERT_NEXT(a_out_sets_valid, clock, reset, (state_ff == ST_OUT), rsp_valid,
                "result beat not raised")
   `ASSERT_IMPLY(a_div_in_div_state, clock, reset, dbusy_ff,
                 (state_ff == ST_KDIV || state_ff == ST_PDIV), "divider busy out of step")
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench
   import rls_pkg::*;
();

   localparam int N = ORDER_DEFAULT;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   // Settling time, long enough for an update for N = 2 or a restart to finish.
   localparam int SETTLE_CYCLES = 600;
   localparam int CYCLE_LIMIT   = 3_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_kind = KIND_UPDATE;
   logic signed [31:0] req_regressor_0 = '0, req_regressor_1 = '0;
   logic signed [31:0] req_regressor_2 = '0, req_regressor_3 = '0;
   logic signed [31:0] req_target_value = '0, req_predicted_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_weight_0, rsp_weight_1, rsp_weight_2, rsp_weight_3;
   logic signed [31:0] rsp_prior_error;
   logic csr_write_enable = 1'b0;
   logic csr_index = CSR_LAMBDA;
   logic [30:0] csr_write_data = '0;

   rls_adaptive_estimator dut (.*);

   typedef struct {
      logic signed [31:0] weight[4];
      logic signed [31:0] err;
   } estimate_type;

   estimate_type expected_estimates[$];
   int  failures = 0;
   int  cycle_count = 0;
   bit  idle_enabled = 1'b1;
   bit  hold_off_request = 1'b0;

   // Predictor state, mirrored from the block
   longint lambda_reg, pdiag_reg;
   longint p_mat[N][N];
   longint w_vec[N];

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic longint clamp32(longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   // floor of a product in Q16.16; arithmetic shift is a floor
   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic estimate_type predict_estimate(logic kind, logic signed [31:0] x_in[4],
                                                  logic signed [31:0] y, logic signed [31:0] u);
      estimate_type r;
      longint x[N], s[N], v[N], k[N];
      longint lam, q, d, acc, t, e;
      e = 0;
      if (kind == KIND_RESTART) begin
         for (int i = 0; i < N; i++) begin
            w_vec[i] = 0;
            for (int j = 0; j < N; j++) p_mat[i][j] = (i == j) ? pdiag_reg : 0;
         end
      end else begin
         lam = (lambda_reg == 0) ? 1 : lambda_reg;
         for (int i = 0; i < N; i++) x[i] = longint'(x_in[i]);
         e = clamp32(longint'(y) - longint'(u));
         for (int i = 0; i < N; i++) begin
            acc = 0;
            for (int j = 0; j < N; j++) acc += qmul(p_mat[i][j], x[j]);
            s[i] = clamp32(acc);
         end
         for (int j = 0; j < N; j++) begin
            acc = 0;
            for (int i = 0; i < N; i++) acc += qmul(x[i], p_mat[i][j]);
            v[j] = clamp32(acc);
         end
         q = 0;
         for (int j = 0; j < N; j++) q += qmul(v[j], x[j]);
         d = lam + q;
         for (int i = 0; i < N; i++) begin
            if (d == 0) k[i] = (s[i] > 0) ? S32_MAX : ((s[i] < 0) ? S32_MIN : 0);
            else k[i] = clamp32((s[i] * 65536) / d);
         end
         for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++) begin
               t = clamp32(p_mat[i][j] - qmul(k[i], v[j]));
               p_mat[i][j] = clamp32((t * 65536) / lam);
            end
         for (int i = 0; i < N; i++) w_vec[i] = clamp32(w_vec[i] + qmul(k[i], e));
      end
      for (int i = 0; i < 4; i++) r.weight[i] = (i < N) ? w_vec[i][31:0] : '0;
      r.err = e[31:0];
      return r;
   endfunction

   // Send one request beat and queue its expected estimate on acceptance
   task automatic send_sample(logic kind, logic signed [31:0] x0, logic signed [31:0] x1,
                              logic signed [31:0] x2, logic signed [31:0] x3,
                              logic signed [31:0] y, logic signed [31:0] u);
      logic signed [31:0] xs[4];
      if (idle_enabled && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 10)) @(posedge clock);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_regressor_0 <= x0; req_regressor_1 <= x1;
      req_regressor_2 <= x2; req_regressor_3 <= x3;
      req_target_value <= y; req_predicted_value <= u;
      xs = '{x0, x1, x2, x3};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_estimates.push_back(predict_estimate(kind, xs, y, u));
      req_valid <= 1'b0;
      // the block is busy after a beat; step on so valid is driven once per edge
      @(posedge clock);
   endtask

   // Wait for every expected beat, let the block settle, then write a register
   task automatic write_register(logic idx, logic [30:0] value);
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_LAMBDA) lambda_reg = value[16:0];
      else pdiag_reg = value;
   endtask

   // Result side: random stall bursts, plus one long hold-off on request
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
         end else if (rsp_stall && idle_enabled && $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check each accepted result beat against the oldest expectation
   always @(posedge clock) begin
      estimate_type exp_est;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_estimates.size() == 0) begin
            $error("unexpected result beat");
            failures++;
         end else begin
            exp_est = expected_estimates.pop_front();
            if (rsp_weight_0 !== exp_est.weight[0]) begin
               $error("weight_0: expected %0d, got %0d", exp_est.weight[0], rsp_weight_0);
               failures++;
            end
            if (rsp_weight_1 !== exp_est.weight[1]) begin
               $error("weight_1: expected %0d, got %0d", exp_est.weight[1], rsp_weight_1);
               failures++;
            end
            if (rsp_weight_2 !== exp_est.weight[2]) begin
               $error("weight_2: expected %0d, got %0d", exp_est.weight[2], rsp_weight_2);
               failures++;
            end
            if (rsp_weight_3 !== exp_est.weight[3]) begin
               $error("weight_3: expected %0d, got %0d", exp_est.weight[3], rsp_weight_3);
               failures++;
            end
            if (rsp_prior_error !== exp_est.err) begin
               $error("prior_error: expected %0d, got %0d", exp_est.err, rsp_prior_error);
               failures++;
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_word();
      unique case ($urandom_range(0, 5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sd131072;
         default: return $signed($urandom());
      endcase
   endfunction

   // Moderate regressor values keep the estimator in a useful range
   function automatic logic signed [31:0] rand_regressor();
      if ($urandom_range(0, 9) == 0) return rand_word();
      return $signed($urandom_range(0, 32'h3FFFF)) - 32'sd131072;
   endfunction

   task automatic test_directed();
      send_sample(KIND_UPDATE, 32'sh10000, 32'sh10000, 0, 0, 32'sh20000, 32'sh10000);
      send_sample(KIND_RESTART, 0, 0, 0, 0, 0, 0);
      send_sample(KIND_UPDATE, 32'sh10000, 32'sh8000, 32'sh7FFFFFFF, 32'sh80000000,
                  32'sh30000, 32'sh10000);
      // saturating error both ways
      send_sample(KIND_UPDATE, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 32'sh7FFFFFFF, 32'sh80000000);
      send_sample(KIND_UPDATE, 32'sh80000000, 32'sh7FFFFFFF, -1, -1, 32'sh80000000, 32'sh7FFFFFFF);
      send_sample(KIND_UPDATE, 0, 0, 0, 0, -1, 0);
      send_sample(KIND_UPDATE, -1, -1, 32'shFFFF, 32'sh1, 0, 0);
      send_sample(KIND_RESTART, -1, -1, -1, -1, -1, -1);
      // update with a unit regressor after a restart
      send_sample(KIND_UPDATE, 32'sh10000, 0, 0, 0, 32'sh10000, 0);
   endtask

   task automatic test_config_extremes();
      write_register(CSR_LAMBDA, 31'd0);      // zero factor used as one
      send_sample(KIND_RESTART, 0, 0, 0, 0, 0, 0);
      send_sample(KIND_UPDATE, 32'sh10000, 32'sh20000, 0, 0, 32'sh10000, 0);
      send_sample(KIND_UPDATE, -32'sh10000, 32'sh10000, 0, 0, 32'sh5000, -32'sh5000);
      write_register(CSR_LAMBDA, 31'h1FFFF);  // factor above one
      write_register(CSR_PDIAG, 31'h7FFFFFFF);
      send_sample(KIND_RESTART, 0, 0, 0, 0, 0, 0);
      send_sample(KIND_UPDATE, 32'sh10000, 32'sh10000, 0, 0, 32'sh10000, 0);
      send_sample(KIND_UPDATE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, -1, 32'sh7FFFFFFF);
      write_register(CSR_LAMBDA, 31'd1);
      write_register(CSR_PDIAG, 31'd1);
      send_sample(KIND_RESTART, 0, 0, 0, 0, 0, 0);
      send_sample(KIND_UPDATE, 32'sh10000, -32'sh10000, 0, 0, 32'sh10000, 0);
      // a large positive diagonal with a lambda of one
      write_register(CSR_LAMBDA, 31'd65536);
      write_register(CSR_PDIAG, 31'h40000000);
      send_sample(KIND_RESTART, 0, 0, 0, 0, 0, 0);
      send_sample(KIND_UPDATE, 32'sh10000, 32'sh10000, 0, 0, 32'sh10000, 0);
   endtask

   // Hold the result side off for a long stretch so requests back up
   task automatic test_backpressure();
      fork
         begin
            hold_off_request = 1'b1;
            repeat (2000) @(posedge clock);
            hold_off_request = 1'b0;
         end
         repeat (6) send_sample(KIND_UPDATE, rand_regressor(), rand_regressor(),
                                rand_word(), rand_word(), rand_word(), rand_word());
      join
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 250 == 0) begin
            write_register(CSR_LAMBDA, 31'($urandom_range(60000, 65536)));
            write_register(CSR_PDIAG, 31'($urandom_range(1, 31'h7FFFFFFF)));
         end
         // mostly sequences of updates; occasional restarts and noise
         if ($urandom_range(0, 29) == 0)
            send_sample(KIND_RESTART, rand_word(), rand_word(), rand_word(), rand_word(),
                        rand_word(), rand_word());
         else if ($urandom_range(0, 9) == 0)
            send_sample(KIND_UPDATE, rand_word(), rand_word(), rand_word(), rand_word(),
                        rand_word(), rand_word());
         else
            send_sample(KIND_UPDATE, rand_regressor(), rand_regressor(), rand_word(),
                        rand_word(), rand_regressor(), rand_regressor());
      end
   endtask

   initial begin
      lambda_reg = LAMBDA_RESET;
      pdiag_reg  = PDIAG_RESET;
      for (int i = 0; i < N; i++) begin
         w_vec[i] = 0;
         for (int j = 0; j < N; j++) p_mat[i][j] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random(1050);
      // last part without idling on either side
      idle_enabled = 1'b0;
      test_random(200);
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
